// ===== src/twm_pkg.sv =====
package twm_pkg;

  localparam int CHARS_DEF  = 64;
  localparam int LEVELS_DEF = 32;

  localparam logic [7:0] SEP_CH  = 8'h2F;
  localparam logic [7:0] STAR_CH = 8'h2A;
  localparam logic [7:0] PLUS_CH = 8'h2B;

  typedef enum logic [1:0] {
    OP_TOPIC   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_EVAL    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_PREAD,
    S_PWAIT,
    S_CELL,
    S_TWAIT,
    S_CRD,
    S_CCMP
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic matched;
    logic lost;
  } twm_res_t;

endpackage

// ===== src/twm_ram.sv =====
module twm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/twm_seq.sv =====
module twm_seq
  import twm_pkg::*;
#(
  parameter int MAX_CHARS  = CHARS_DEF,
  parameter int MAX_LEVELS = LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [$clog2(MAX_CHARS):0]     tlen,
  input  logic [$clog2(MAX_CHARS):0]     plen,
  output logic [$clog2(MAX_CHARS)-1:0]   t_raddr,
  output logic [$clog2(MAX_CHARS)-1:0]   p_raddr,
  input  logic [7:0]                     t_rdata,
  input  logic [7:0]                     p_rdata,
  output twm_res_t                       res
);

  localparam int CW  = $clog2(MAX_CHARS);
  localparam int LW  = $clog2(MAX_LEVELS);
  localparam int JW  = $clog2(MAX_LEVELS + 1);
  localparam int NR  = MAX_LEVELS + 1;
  localparam int LEW = 2 * CW + 3;
  localparam int LDEPTH = 2 * (2 ** LW);

  seq_state_t state_r, state_nxt;

  logic          sel_r, sel_nxt;
  logic [CW:0]   acnt_r, acnt_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pidx_r, pidx_nxt;
  logic          inside_r, inside_nxt;
  logic          keep_r, keep_nxt;
  logic [JW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cstart_r, cstart_nxt;
  logic [CW:0]   clen_r, clen_nxt;
  logic          lost_r, lost_nxt;
  logic [JW-1:0] tn_r, tn_nxt;
  logic [JW-1:0] pn_r, pn_nxt;
  logic [JW-1:0] i_r, i_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [CW-1:0] ps_r, ps_nxt;
  logic [CW:0]   pl_r, pl_nxt;
  logic          pstar_r, pstar_nxt;
  logic          pplus_r, pplus_nxt;
  logic [CW-1:0] ts_r, ts_nxt;
  logic [CW:0]   k_r, k_nxt;
  logic [NR-1:0] nrow_r, nrow_nxt;
  logic [NR-1:0] crow_r, crow_nxt;
  logic          res_r, res_nxt;
  logic          done_r, done_nxt;

  logic             lv_we;
  logic [LW:0]      lv_waddr;
  logic [LEW-1:0]   lv_wdata;
  logic [LW:0]      lv_raddr;
  logic [LEW-1:0]   lv_rdata;

  logic [7:0]    ch;
  logic [CW:0]   len_sel;
  logic          split_end;
  logic [NR-1:0] nshift;
  logic          nb;
  logic          cb;
  logic          fin;
  logic          fv;
  logic [CW:0]   e_len;
  logic [CW-1:0] e_start;
  logic [NR-1:0] crow_upd;

  twm_ram #(.WIDTH(LEW), .DEPTH(LDEPTH)) u_lvl (
    .clk   (clk),
    .we    (lv_we),
    .waddr (lv_waddr),
    .wdata (lv_wdata),
    .raddr (lv_raddr),
    .rdata (lv_rdata)
  );

  assign ch        = sel_r ? p_rdata : t_rdata;
  assign len_sel   = sel_r ? plen : tlen;
  assign split_end = !pend_r && (acnt_r == len_sel);
  assign nshift    = nrow_r >> 1;
  assign nb        = nshift[j_r];
  assign cb        = crow_r[j_r + JW'(1)];
  assign e_start   = lv_rdata[LEW-1 -: CW];
  assign e_len     = lv_rdata[CW+2 -: CW+1];

  // cell resolution: fin when the current table entry is known
  always_comb begin
    fin      = 1'b0;
    fv       = 1'b0;
    case (state_r)
      S_CELL: begin
        if (pstar_r && (i_r == pn_r - JW'(1))) begin
          fin = 1'b1;
          fv  = 1'b1;
        end else if (j_r == tn_r) begin
          fin = 1'b1;
        end else if (pstar_r) begin
          fin = 1'b1;
          fv  = nb | cb;
        end else if (pplus_r) begin
          fin = 1'b1;
          fv  = nb;
        end else if (!nb) begin
          fin = 1'b1;
        end
      end
      S_TWAIT: begin
        fin = (e_len != pl_r);
      end
      S_CCMP: begin
        if (t_rdata != p_rdata) begin
          fin = 1'b1;
        end else if (k_r + (CW+1)'(1) == pl_r) begin
          fin = 1'b1;
          fv  = 1'b1;
        end
      end
      default: ;
    endcase
    crow_upd      = crow_r;
    crow_upd[j_r] = fv;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_SPLIT;
      S_SPLIT: begin
        if (split_end && sel_r) begin
          state_nxt = (cnt_r == '0) ? S_IDLE : S_PREAD;
        end
      end
      S_PREAD: state_nxt = S_PWAIT;
      S_PWAIT: state_nxt = S_CELL;
      S_CELL, S_TWAIT, S_CCMP: begin
        if (fin) begin
          if (j_r == '0) begin
            state_nxt = (i_r == '0) ? S_IDLE : S_PREAD;
          end else begin
            state_nxt = S_CELL;
          end
        end else if (state_r == S_CELL) begin
          state_nxt = S_TWAIT;
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_CRD:   state_nxt = S_CCMP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sel_nxt    = sel_r;
    acnt_nxt   = acnt_r;
    pend_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    inside_nxt = inside_r;
    keep_nxt   = keep_r;
    cnt_nxt    = cnt_r;
    cstart_nxt = cstart_r;
    clen_nxt   = clen_r;
    lost_nxt   = lost_r;
    tn_nxt     = tn_r;
    pn_nxt     = pn_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ps_nxt     = ps_r;
    pl_nxt     = pl_r;
    pstar_nxt  = pstar_r;
    pplus_nxt  = pplus_r;
    ts_nxt     = ts_r;
    k_nxt      = k_r;
    nrow_nxt   = nrow_r;
    crow_nxt   = crow_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;
    lv_we      = 1'b0;
    lv_waddr   = '0;
    lv_wdata   = '0;
    lv_raddr   = '0;
    t_raddr    = acnt_r[CW-1:0];
    p_raddr    = acnt_r[CW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          sel_nxt    = 1'b0;
          acnt_nxt   = '0;
          inside_nxt = 1'b0;
          keep_nxt   = 1'b0;
          cnt_nxt    = '0;
          lost_nxt   = 1'b0;
        end
      end
      S_SPLIT: begin
        if (acnt_r != len_sel) begin
          pend_nxt = 1'b1;
          pidx_nxt = acnt_r[CW-1:0];
          acnt_nxt = acnt_r + (CW+1)'(1);
        end
        if (pend_r) begin
          if (ch == SEP_CH) begin
            inside_nxt = 1'b0;
          end else if (!inside_r) begin
            inside_nxt = 1'b1;
            if (cnt_r < JW'(MAX_LEVELS)) begin
              cstart_nxt = pidx_r;
              clen_nxt   = (CW+1)'(1);
              cnt_nxt    = cnt_r + JW'(1);
              keep_nxt   = 1'b1;
              lv_we      = 1'b1;
              lv_waddr   = {sel_r, cnt_r[LW-1:0]};
              lv_wdata   = {pidx_r, (CW+1)'(1), ch == STAR_CH, ch == PLUS_CH};
            end else begin
              lost_nxt = 1'b1;
              keep_nxt = 1'b0;
            end
          end else if (keep_r) begin
            clen_nxt = clen_r + (CW+1)'(1);
            lv_we    = 1'b1;
            lv_waddr = {sel_r, LW'(cnt_r - JW'(1))};
            lv_wdata = {cstart_r, clen_r + (CW+1)'(1), 1'b0, 1'b0};
          end
        end
        if (split_end) begin
          acnt_nxt   = '0;
          inside_nxt = 1'b0;
          keep_nxt   = 1'b0;
          cnt_nxt    = '0;
          if (!sel_r) begin
            tn_nxt  = cnt_r;
            sel_nxt = 1'b1;
          end else begin
            pn_nxt   = cnt_r;
            nrow_nxt = NR'(1) << tn_r;
            i_nxt    = cnt_r - JW'(1);
            if (cnt_r == '0) begin
              res_nxt  = (tn_r == '0);
              done_nxt = 1'b1;
            end
          end
        end
      end
      S_PREAD: begin
        lv_raddr = {1'b1, i_r[LW-1:0]};
      end
      S_PWAIT: begin
        ps_nxt    = e_start;
        pl_nxt    = e_len;
        pstar_nxt = lv_rdata[1];
        pplus_nxt = lv_rdata[0];
        j_nxt     = tn_r;
      end
      S_CELL: begin
        lv_raddr = {1'b0, j_r[LW-1:0]};
      end
      S_TWAIT: begin
        ts_nxt = e_start;
        k_nxt  = '0;
      end
      S_CRD: begin
        t_raddr = ts_r + k_r[CW-1:0];
        p_raddr = ps_r + k_r[CW-1:0];
      end
      S_CCMP: begin
        k_nxt = k_r + (CW+1)'(1);
      end
      default: ;
    endcase

    if (fin) begin
      crow_nxt = crow_upd;
      if (j_r == '0) begin
        nrow_nxt = crow_upd;
        if (i_r == '0) begin
          res_nxt  = fv;
          done_nxt = 1'b1;
        end else begin
          i_nxt = i_r - JW'(1);
        end
      end else begin
        j_nxt = j_r - JW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
    end
    sel_r    <= sel_nxt;
    acnt_r   <= acnt_nxt;
    pidx_r   <= pidx_nxt;
    inside_r <= inside_nxt;
    keep_r   <= keep_nxt;
    cnt_r    <= cnt_nxt;
    cstart_r <= cstart_nxt;
    clen_r   <= clen_nxt;
    lost_r   <= lost_nxt;
    tn_r     <= tn_nxt;
    pn_r     <= pn_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    ps_r     <= ps_nxt;
    pl_r     <= pl_nxt;
    pstar_r  <= pstar_nxt;
    pplus_r  <= pplus_nxt;
    ts_r     <= ts_nxt;
    k_r      <= k_nxt;
    nrow_r   <= nrow_nxt;
    crow_r   <= crow_nxt;
    res_r    <= res_nxt;
  end

  assign res.done    = done_r;
  assign res.matched = res_r;
  assign res.lost    = lost_r;

endmodule

// ===== src/topic_wildcard_matcher_top.sv =====
// channel | ports                                   | direction
// in      | in_valid in_stall in_operation in_char_byte | input transaction
// out     | out_valid out_stall out_matched out_overflowed | result transaction
//
// One append transaction may follow every cycle while no evaluation is busy.
// Evaluate: split of both strings into levels, then one pattern row at a time
// (last level first), resolved one topic level per cell; a plain level that
// must be compared reads its topic level entry and then compares byte by byte.
// The level RAM is shared by topic and pattern levels and has one read port.
// Reset (rst_n low, synchronous) empties both strings and clears the flag;
// in_stall is high while evaluating and for an evaluate while a result waits.
module topic_wildcard_matcher_top
  import twm_pkg::*;
#(
  parameter int MAX_CHARS  = CHARS_DEF,
  parameter int MAX_LEVELS = LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_overflowed
);

  localparam int CW = $clog2(MAX_CHARS);

  logic [CW:0]   tlen_r, tlen_nxt;
  logic [CW:0]   plen_r, plen_nxt;
  logic          trunc_r, trunc_nxt;
  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_matched_r, out_matched_nxt;
  logic          out_overflowed_r, out_overflowed_nxt;

  logic          acc;
  logic          eval_go;
  logic          t_we, p_we;
  logic [CW-1:0] t_raddr, p_raddr;
  logic [7:0]    t_rdata, p_rdata;
  twm_res_t      res;

  assign in_stall = busy_r || (out_valid_r && (in_operation == OP_EVAL));
  assign acc      = in_valid && !in_stall;
  assign eval_go  = acc && (in_operation == OP_EVAL);
  assign t_we     = acc && (in_operation == OP_TOPIC) && (tlen_r < (CW+1)'(MAX_CHARS));
  assign p_we     = acc && (in_operation == OP_PATTERN) && (plen_r < (CW+1)'(MAX_CHARS));

  twm_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_topic (
    .clk   (clk),
    .we    (t_we),
    .waddr (tlen_r[CW-1:0]),
    .wdata (in_char_byte),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  twm_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_pattern (
    .clk   (clk),
    .we    (p_we),
    .waddr (plen_r[CW-1:0]),
    .wdata (in_char_byte),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  twm_seq #(.MAX_CHARS(MAX_CHARS), .MAX_LEVELS(MAX_LEVELS)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (eval_go),
    .tlen    (tlen_r),
    .plen    (plen_r),
    .t_raddr (t_raddr),
    .p_raddr (p_raddr),
    .t_rdata (t_rdata),
    .p_rdata (p_rdata),
    .res     (res)
  );

  always_comb begin
    tlen_nxt           = tlen_r;
    plen_nxt           = plen_r;
    trunc_nxt          = trunc_r;
    busy_nxt           = busy_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_matched_nxt    = out_matched_r;
    out_overflowed_nxt = out_overflowed_r;
    if (acc) begin
      case (in_operation)
        OP_TOPIC: begin
          if (t_we) tlen_nxt = tlen_r + (CW+1)'(1);
          else      trunc_nxt = 1'b1;
        end
        OP_PATTERN: begin
          if (p_we) plen_nxt = plen_r + (CW+1)'(1);
          else      trunc_nxt = 1'b1;
        end
        OP_EVAL: busy_nxt = 1'b1;
        default: ;
      endcase
    end
    if (res.done) begin
      busy_nxt           = 1'b0;
      out_valid_nxt      = 1'b1;
      out_matched_nxt    = res.matched;
      out_overflowed_nxt = trunc_r || res.lost;
      tlen_nxt           = '0;
      plen_nxt           = '0;
      trunc_nxt          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r      <= '0;
      plen_r      <= '0;
      trunc_r     <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tlen_r      <= tlen_nxt;
      plen_r      <= plen_nxt;
      trunc_r     <= trunc_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_matched_r    <= out_matched_nxt;
    out_overflowed_r <= out_overflowed_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_matched    = out_matched_r;
  assign out_overflowed = out_overflowed_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    eval_go |-> !busy_r && !out_valid_r)
    else $error("evaluate started while busy or result pending");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> busy_r)
    else $error("evaluation finished while not busy");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (tlen_r <= (CW+1)'(MAX_CHARS)) && (plen_r <= (CW+1)'(MAX_CHARS)))
    else $error("string length beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |=> tlen_r == '0 && plen_r == '0 && out_valid_r)
    else $error("strings not cleared after evaluate");

endmodule
